### sv/rvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvs_pkg: shared constants and trig tables for the rotated view sampler
// Holds the default geometry, the pipeline latency, the quarter-wave sine
// table in Q1.14 and the helper that folds a heading onto that table.
// ----------------------------------------------------------------------------
package rvs_pkg;

    // Default geometry
    localparam int WORLD_W_DEF  = 1024;
    localparam int WORLD_H_DEF  = 1024;
    localparam int VIEW_MAX_DEF = 256;

    // Cycles from an accepted sample word to its result strobe
    localparam int LATENCY = 6;

    // Angle constants in degrees
    localparam logic [8:0] DEG_90  = 9'd90;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_270 = 9'd270;
    localparam logic [8:0] DEG_360 = 9'd360;

    // Fixed-point constants for building the table
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    // Command codes
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef logic [14:0] t_quarter_rom [0:90];

    // Folded angle: table index and sign
    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } t_fold;

    // Raise a Q30 series term by two powers of the Q30 angle
    function automatic longint unsigned series_pow2(input longint unsigned term,
                                                    input longint unsigned x);
        longint unsigned t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // Q14 sine of d degrees for 0..90, evaluated at elaboration by a Q30 series
    function automatic logic [14:0] quarter_sin(input int unsigned d);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x    = (longint'(d) * PI_Q30 + 64'd90) / 64'd180;
        term = x;
        sum  = longint'(x);
        // nine terms, each divided by (2k)(2k+1), with alternating sign
        term = series_pow2(term, x) / 64'd6;
        sum  = sum - longint'(term);
        term = series_pow2(term, x) / 64'd20;
        sum  = sum + longint'(term);
        term = series_pow2(term, x) / 64'd42;
        sum  = sum - longint'(term);
        term = series_pow2(term, x) / 64'd72;
        sum  = sum + longint'(term);
        term = series_pow2(term, x) / 64'd110;
        sum  = sum - longint'(term);
        term = series_pow2(term, x) / 64'd156;
        sum  = sum + longint'(term);
        term = series_pow2(term, x) / 64'd210;
        sum  = sum - longint'(term);
        term = series_pow2(term, x) / 64'd272;
        sum  = sum + longint'(term);
        term = series_pow2(term, x) / 64'd342;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        return 15'((longint'(sum) + 64'd32768) >> 16);
    endfunction

    function automatic t_quarter_rom build_quarter_rom();
        t_quarter_rom rom;
        for (int d = 0; d <= 90; d++) begin
            rom[d] = quarter_sin(d);
        end
        return rom;
    endfunction

    localparam t_quarter_rom QUARTER_SIN = build_quarter_rom();

    // Fold an angle of 0..359 degrees onto the quarter wave
    function automatic t_fold fold_angle(input logic [8:0] deg);
        t_fold f;
        if (deg <= DEG_90) begin
            f.neg = 1'b0;
            f.idx = deg[6:0];
        end else if (deg <= DEG_180) begin
            f.neg = 1'b0;
            f.idx = 7'(DEG_180 - deg);
        end else if (deg <= DEG_270) begin
            f.neg = 1'b1;
            f.idx = 7'(deg - DEG_180);
        end else begin
            f.neg = 1'b1;
            f.idx = 7'(DEG_360 - deg);
        end
        return f;
    endfunction

    // Signed Q1.14 value from a folded angle
    function automatic logic signed [15:0] trig_value(input t_fold f);
        logic signed [15:0] mag;
        mag = $signed({1'b0, QUARTER_SIN[f.idx]});
        return f.neg ? -mag : mag;
    endfunction

endpackage
`default_nettype wire

### sv/rotated_view_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_view_sampler: nearest-neighbour sampler of a rotated view window
// Keeps a world image of byte pixels and returns the pixel under a view
// point rotated by a whole-degree heading around a viewer centre.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the fields and raise start; a word is taken at
//   each rising edge with start high and busy low. A write word (cmd 0)
//   stores i_pixel_in at (i_center_x, i_center_y) and gives no result; a
//   write outside the world is dropped. A sample word (cmd 1) gives one
//   result, o_pixel_out and o_outside, strobed by o_valid for one cycle.
//   Config channel: i_cfg_data loads the outside colour at an edge with
//   i_cfg_valid and o_cfg_ready high; write it only while the block is idle.
//   Throughput: one word per cycle once out of reset, set by the six-stage
//   pipeline of capture, table lookup, multiply, sum and truncate, address
//   multiply, and the single world memory port, which serves a write or a
//   read each cycle in command order.
//   Reset: busy stays high during reset and for one cycle after; the
//   pipeline empties and the outside colour returns to 0. World pixels are
//   undefined until written, and nothing clears them.
//   Results cannot be held off by the receiver and need no back-pressure.
// ----------------------------------------------------------------------------
module rotated_view_sampler
    import rvs_pkg::*;
#(
    parameter int WORLD_W  = WORLD_W_DEF,
    parameter int WORLD_H  = WORLD_H_DEF,
    parameter int VIEW_MAX = VIEW_MAX_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_cmd,
    input  wire logic [9:0]        i_center_x,
    input  wire logic [9:0]        i_center_y,
    input  wire logic [8:0]        i_heading,
    input  wire logic [7:0]        i_view_row,
    input  wire logic signed [7:0] i_col_offset,
    input  wire logic [7:0]        i_pixel_in,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [7:0]        i_cfg_data,
    output logic                   o_valid,
    output logic [7:0]             o_pixel_out,
    output logic                   o_outside
);

    localparam int DEPTH = WORLD_W * WORLD_H;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [10:0]        ROW_LIM = 11'(VIEW_MAX);
    localparam logic signed [11:0] COL_MIN = -12'(VIEW_MAX / 2);
    localparam logic signed [11:0] COL_MAX = 12'(VIEW_MAX / 2 - 1);
    localparam logic signed [13:0] W_LIM   = 14'(WORLD_W);
    localparam logic signed [13:0] H_LIM   = 14'(WORLD_H);
    localparam logic [23:0]        W_MUL   = 24'(WORLD_W);
    localparam logic signed [25:0] TRUNC_BIAS = 26'sd16383;

    // Stage payloads
    typedef struct packed {
        t_cmd               cmd;
        logic [9:0]         cx;
        logic [9:0]         cy;
        logic [8:0]         hd;
        logic [7:0]         row;
        logic signed [7:0]  col;
        logic [7:0]         pix;
    } t_s1;

    typedef struct packed {
        t_cmd               cmd;
        logic [9:0]         cx;
        logic [9:0]         cy;
        logic [7:0]         row;
        logic signed [7:0]  col;
        logic [7:0]         pix;
        logic signed [15:0] sin_v;
        logic signed [15:0] cos_v;
        logic               ovf;
    } t_s2;

    typedef struct packed {
        t_cmd               cmd;
        logic [9:0]         cx;
        logic [9:0]         cy;
        logic [7:0]         pix;
        logic               ovf;
        logic signed [23:0] p_cc;
        logic signed [24:0] p_rs;
        logic signed [23:0] p_cs;
        logic signed [24:0] p_rc;
    } t_s3;

    typedef struct packed {
        t_cmd               cmd;
        logic [7:0]         pix;
        logic               ovf;
        logic signed [13:0] px;
        logic signed [13:0] py;
    } t_s4;

    typedef struct packed {
        logic               wr;
        logic               smp;
        logic               outside;
        logic [AW-1:0]      addr;
        logic [7:0]         pix;
    } t_s5;

    logic       r_busy;
    logic [7:0] r_outside_color;
    logic       r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    t_s1        r_s1, n_s1;
    t_s2        r_s2, n_s2;
    t_s3        r_s3, n_s3;
    t_s4        r_s4, n_s4;
    t_s5        r_s5, n_s5;
    logic       r_out_vld;
    logic       r_out_outside;
    logic [7:0] r_rd_data;
    logic [7:0] r_mem [DEPTH];

    logic       accept;
    logic [8:0] cos_deg;
    logic signed [11:0] col_ext;
    logic signed [25:0] sum_x, sum_y, tr_x, tr_y;
    logic signed [11:0] dx, dy;
    logic       in_world;

    assign accept = start && !r_busy;

    // Stage 0: capture the word and bring the heading into 0..359
    always_comb begin
        n_s1.cmd = t_cmd'(i_cmd);
        n_s1.cx  = i_center_x;
        n_s1.cy  = i_center_y;
        n_s1.hd  = (i_heading >= DEG_360) ? 9'(i_heading - DEG_360) : i_heading;
        n_s1.row = i_view_row;
        n_s1.col = i_col_offset;
        n_s1.pix = i_pixel_in;
    end

    // Stage 1: table lookups and window overflow check
    always_comb begin
        cos_deg = 9'(r_s1.hd + DEG_90);
        if (cos_deg >= DEG_360) begin
            cos_deg = 9'(cos_deg - DEG_360);
        end
        col_ext    = 12'(r_s1.col);
        n_s2.cmd   = r_s1.cmd;
        n_s2.cx    = r_s1.cx;
        n_s2.cy    = r_s1.cy;
        n_s2.row   = r_s1.row;
        n_s2.col   = r_s1.col;
        n_s2.pix   = r_s1.pix;
        n_s2.sin_v = trig_value(fold_angle(r_s1.hd));
        n_s2.cos_v = trig_value(fold_angle(cos_deg));
        n_s2.ovf   = ({3'b000, r_s1.row} >= ROW_LIM) || (col_ext < COL_MIN)
                     || (col_ext > COL_MAX);
    end

    // Stage 2: the four rotation products
    always_comb begin
        n_s3.cmd  = r_s2.cmd;
        n_s3.cx   = r_s2.cx;
        n_s3.cy   = r_s2.cy;
        n_s3.pix  = r_s2.pix;
        n_s3.ovf  = r_s2.ovf;
        n_s3.p_cc = r_s2.col * r_s2.cos_v;
        n_s3.p_rs = $signed({1'b0, r_s2.row}) * r_s2.sin_v;
        n_s3.p_cs = r_s2.col * r_s2.sin_v;
        n_s3.p_rc = $signed({1'b0, r_s2.row}) * r_s2.cos_v;
    end

    // Stage 3: sum, truncate toward zero, offset a sample word from the centre
    always_comb begin
        sum_x = 26'(r_s3.p_cc) + 26'(r_s3.p_rs);
        sum_y = 26'(r_s3.p_cs) - 26'(r_s3.p_rc);
        tr_x  = (sum_x + (sum_x[25] ? TRUNC_BIAS : 26'sd0)) >>> 14;
        tr_y  = (sum_y + (sum_y[25] ? TRUNC_BIAS : 26'sd0)) >>> 14;
        dx    = tr_x[11:0];
        dy    = tr_y[11:0];
        n_s4.cmd = r_s3.cmd;
        n_s4.pix = r_s3.pix;
        n_s4.ovf = r_s3.ovf;
        if (r_s3.cmd == CMD_WRITE) begin
            n_s4.px = $signed({4'b0000, r_s3.cx});
            n_s4.py = $signed({4'b0000, r_s3.cy});
        end else begin
            n_s4.px = $signed({4'b0000, r_s3.cx}) + 14'(dx);
            n_s4.py = $signed({4'b0000, r_s3.cy}) + 14'(dy);
        end
    end

    // Stage 4: bounds check and row-major address
    always_comb begin
        in_world = (r_s4.px >= 14'sd0) && (r_s4.px < W_LIM)
                   && (r_s4.py >= 14'sd0) && (r_s4.py < H_LIM);
        n_s5.wr      = (r_s4.cmd == CMD_WRITE) && in_world;
        n_s5.smp     = (r_s4.cmd == CMD_SAMPLE);
        n_s5.outside = r_s4.ovf || !in_world;
        n_s5.addr    = AW'(({12'h000, r_s4.py[11:0]} * W_MUL)
                           + {12'h000, r_s4.px[11:0]});
        n_s5.pix     = r_s4.pix;
    end

    // Hold control state: busy, config, stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b1;
            r_outside_color <= 8'h00;
            r_s1_vld        <= 1'b0;
            r_s2_vld        <= 1'b0;
            r_s3_vld        <= 1'b0;
            r_s4_vld        <= 1'b0;
            r_s5_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_outside_color <= i_cfg_data;
            end
            r_s1_vld  <= accept;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_out_vld <= r_s5_vld && r_s5.smp;
        end
    end

    // Advance the stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        r_s2          <= n_s2;
        r_s3          <= n_s3;
        r_s4          <= n_s4;
        r_s5          <= n_s5;
        r_out_outside <= r_s5.outside;
    end

    // World memory: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_s5_vld && r_s5.wr) begin
            r_mem[r_s5.addr] <= r_s5.pix;
        end
        r_rd_data <= r_mem[r_s5.addr];
    end

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign o_valid     = r_out_vld;
    assign o_outside   = r_out_outside;
    assign o_pixel_out = r_out_outside ? r_outside_color : r_rd_data;

endmodule
`default_nettype wire

### sv/rvs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvs_checker: port-level checks for the rotated view sampler
// Watches the command and result ports for pipeline timing and the
// centre-pixel case.
// ----------------------------------------------------------------------------
module rvs_checker
    import rvs_pkg::*;
#(
    parameter int WORLD_W = WORLD_W_DEF,
    parameter int WORLD_H = WORLD_H_DEF
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              i_cmd,
    input wire logic [9:0]        i_center_x,
    input wire logic [9:0]        i_center_y,
    input wire logic [7:0]        i_view_row,
    input wire logic signed [7:0] i_col_offset,
    input wire logic              o_valid,
    input wire logic              o_outside
);

    logic smp_word;
    logic centre_in;

    assign smp_word  = start && !busy && (i_cmd == CMD_SAMPLE);
    assign centre_in = (32'(i_center_x) < WORLD_W) && (32'(i_center_y) < WORLD_H)
                       && (i_view_row == 8'd0) && (i_col_offset == 8'sd0);

    // The pipeline takes a word every cycle once out of reset
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset");

    // Every sample word gives a strobe after the fixed latency
    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_word |-> ##LATENCY o_valid)
        else $error("sample word lost");

    // No strobe without a sample word that long ago
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(smp_word, LATENCY))
        else $error("result strobe without a sample word");

    // A zero offset from a centre inside the world reads the world
    a_centre_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (smp_word && centre_in) |-> ##LATENCY (o_valid && !o_outside))
        else $error("centre pixel reported outside");

endmodule

bind rotated_view_sampler rvs_checker #(
    .WORLD_W(WORLD_W),
    .WORLD_H(WORLD_H)
) u_rvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .i_center_x  (i_center_x),
    .i_center_y  (i_center_y),
    .i_view_row  (i_view_row),
    .i_col_offset(i_col_offset),
    .o_valid     (o_valid),
    .o_outside   (o_outside)
);
`default_nettype wire
